/* hdl/block_texture_decoder_unit_defines.svh */
// ---------------------------------------------------------------------------
// Block texture decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BLOCK_TEXTURE_DECODER_UNIT_DEFINES_SVH
`define BLOCK_TEXTURE_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define BCTD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bctd: same-cycle check failed");

// next-cycle implication
`define BCTD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bctd: next-cycle check failed");

`endif

/* hdl/bctd_pkg.sv */
// ---------------------------------------------------------------------------
// Block texture decoder package
// Format codes, queue entry type and constant-divide helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package bctd_pkg;

	// block format codes; any other code decodes as BC1
	localparam logic [1:0] FMT_BC1 = 2'd0;
	localparam logic [1:0] FMT_BC2 = 2'd1;
	localparam logic [1:0] FMT_BC3 = 2'd2;

	localparam int ROWS    = 4;
	localparam int COLS    = 4;
	localparam int QDEPTH  = 2;
	localparam int QIDX_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// decoded block waiting for row emission
	typedef struct packed {
		logic [1:0]        fmt;
		logic [3:0][31:0]  cpal;
		logic [31:0]       cidx;
		logic [7:0][7:0]   apal;
		logic [63:0]       ahalf;
	} entry_t;

	// RGB565 -> RGB888 by bit replication
	function automatic logic [23:0] widen565(input logic [15:0] c);
		logic [7:0] r, g, b;
		r = {c[15:11], c[15:13]};
		g = {c[10:5], c[10:9]};
		b = {c[4:0], c[4:2]};
		return {r, g, b};
	endfunction

	// x / 3 for x < 768: x * 683 >> 11
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'd683;
		return p[18:11];
	endfunction

	// x / 7 for x < 1792: x * 2341 >> 14
	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd2341;
		return p[21:14];
	endfunction

	// x / 5 for x < 1280: x * 1639 >> 13
	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [21:0] p;
		p = 22'(x) * 22'd1639;
		return p[20:13];
	endfunction

endpackage

`default_nettype wire

/* hdl/bctd_front.sv */
// ---------------------------------------------------------------------------
// Block texture decoder front end
// Accepts compressed blocks, builds colour and alpha palettes, pushes them
// to the entry queue.
// ---------------------------------------------------------------------------
`default_nettype none

module bctd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     fmt,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [63:0]    color_half,
	input  wire logic [63:0]    alpha_half,
	output logic                push_valid,
	input  wire logic           push_ready,
	output bctd_pkg::entry_t    push_data
);
	import bctd_pkg::*;

	logic        v_s1;
	logic [63:0] ch_s1;
	logic [63:0] ah_s1;
	logic [1:0]  fmt_s1;

	// input stage: holds one block until the queue takes it
	assign in_ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1  <= color_half;
			ah_s1  <= alpha_half;
			fmt_s1 <= fmt;
		end
	end

	// colour palette
	logic [23:0]      e0, e1;
	logic             three;
	logic [3:0][31:0] cpal;

	always_comb begin
		logic [23:0] mid, t2, t3;
		logic [9:0]  s2, s3;
		logic [8:0]  sa;
		e0 = widen565(ch_s1[15:0]);
		e1 = widen565(ch_s1[31:16]);
		three = (fmt_s1 != FMT_BC2) && (fmt_s1 != FMT_BC3) &&
			(ch_s1[15:0] <= ch_s1[31:16]);
		for (int k = 0; k < 3; k++) begin
			s2 = {1'b0, e0[8*k +: 8], 1'b0} + 10'(e1[8*k +: 8]);
			s3 = 10'(e0[8*k +: 8]) + {1'b0, e1[8*k +: 8], 1'b0};
			sa = 9'(e0[8*k +: 8]) + 9'(e1[8*k +: 8]);
			t2[8*k +: 8]  = div3(s2);
			t3[8*k +: 8]  = div3(s3);
			mid[8*k +: 8] = sa[8:1];
		end
		cpal[0] = {8'hFF, e0};
		cpal[1] = {8'hFF, e1};
		cpal[2] = three ? {8'hFF, mid} : {8'hFF, t2};
		cpal[3] = three ? 32'h0 : {8'hFF, t3};
	end

	// BC3 alpha palette
	logic [7:0]      a0, a1;
	logic [7:0][7:0] apal;

	always_comb begin
		logic [10:0] s7;
		logic [10:0] s5;
		a0 = ah_s1[7:0];
		a1 = ah_s1[15:8];
		apal[0] = a0;
		apal[1] = a1;
		for (int i = 2; i < 8; i++) begin
			s7 = 11'(8 - i) * 11'(a0) + 11'(i - 1) * 11'(a1);
			s5 = 11'(6 - i) * 11'(a0) + 11'(i - 1) * 11'(a1);
			if (a0 > a1) begin
				apal[i] = div7(s7);
			end else if (i < 6) begin
				apal[i] = div5(s5);
			end else if (i == 6) begin
				apal[i] = 8'h00;
			end else begin
				apal[i] = 8'hFF;
			end
		end
	end

	assign push_valid      = v_s1;
	assign push_data.fmt   = fmt_s1;
	assign push_data.cpal  = cpal;
	assign push_data.cidx  = ch_s1[63:32];
	assign push_data.apal  = apal;
	assign push_data.ahalf = ah_s1;

endmodule

`default_nettype wire

/* hdl/bctd_queue.sv */
// ---------------------------------------------------------------------------
// Block texture decoder entry queue
// Short FIFO of decoded palettes between front end and row emitter.
// ---------------------------------------------------------------------------
`default_nettype none

module bctd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire bctd_pkg::entry_t  push_data,
	output logic                   head_valid,
	input  wire logic              pop,
	output bctd_pkg::entry_t       head_data
);
	import bctd_pkg::*;

	entry_t            slot_q [QDEPTH];
	logic [QIDX_W-1:0] wr_ptr_q;
	logic [QIDX_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;
	assign head_data  = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* hdl/bctd_back.sv */
// ---------------------------------------------------------------------------
// Block texture decoder back end
// Emits four pixel rows per queued block through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bctd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire bctd_pkg::entry_t  head_data,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             row_index,
	output logic [31:0]            pixel_a,
	output logic [31:0]            pixel_b,
	output logic [31:0]            pixel_c,
	output logic [31:0]            pixel_d,
	output logic                   last_row
);
	import bctd_pkg::*;

	logic [1:0]  row_q;
	logic        out_valid_q;
	logic [1:0]  orow_q;
	logic        last_q;
	logic [31:0] pix_q [COLS];
	logic        load;
	logic [31:0] pix [COLS];

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && (row_q == 2'(ROWS - 1));

	// pixels of the current row
	always_comb begin
		logic [3:0]  p;
		logic [1:0]  ci;
		logic [3:0]  nib;
		logic [2:0]  ai;
		logic [31:0] px;
		for (int c = 0; c < COLS; c++) begin
			p   = {row_q, 2'(c)};
			ci  = head_data.cidx[2*p +: 2];
			nib = head_data.ahalf[4*p +: 4];
			ai  = head_data.ahalf[16 + 3*p +: 3];
			px  = head_data.cpal[ci];
			case (head_data.fmt)
				FMT_BC2: pix[c] = {nib, nib, px[23:0]};
				FMT_BC3: pix[c] = {head_data.apal[ai], px[23:0]};
				default: pix[c] = px;
			endcase
		end
	end

	// row counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			row_q       <= row_q + 1'b1;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			orow_q <= row_q;
			last_q <= (row_q == 2'(ROWS - 1));
			for (int c = 0; c < COLS; c++) begin
				pix_q[c] <= pix[c];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = orow_q;
	assign last_row  = last_q;
	assign pixel_a   = pix_q[0];
	assign pixel_b   = pix_q[1];
	assign pixel_c   = pix_q[2];
	assign pixel_d   = pix_q[3];

endmodule

`default_nettype wire

/* hdl/block_texture_decoder_unit.sv */
// A block passes through the front-end input register, the entry queue and the
// output register before its first row appears. Rows leave at one row per cycle
//   while out_ready is high; the single output channel, carrying four rows per block, limits block rate.
// The front end keeps accepting blocks while the two-entry queue has room or its input stage is empty.
// Reset: empties the pipeline and queue and sets the format register to BC1.
// ---------------------------------------------------------------------------
// Block texture decoder top level
// BC1/BC2/BC3 4x4 block decompressor with a format register port.
// ---------------------------------------------------------------------------
`default_nettype none
`include "block_texture_decoder_unit_defines.svh"

module block_texture_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] color_half,
	input  wire logic [63:0] alpha_half,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       row_index,
	output logic [31:0]      pixel_a,
	output logic [31:0]      pixel_b,
	output logic [31:0]      pixel_c,
	output logic [31:0]      pixel_d,
	output logic             last_row
);
	import bctd_pkg::*;

	logic [1:0] fmt_q;
	logic       push_valid;
	logic       push_ready;
	entry_t     push_data;
	logic       head_valid;
	entry_t     head_data;
	logic       pop;

	// format register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_BC1;
		end else if (cfg_valid && cfg_ready) begin
			fmt_q <= cfg_data;
		end
	end

	bctd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fmt        (fmt_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.color_half (color_half),
		.alpha_half (alpha_half),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bctd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data)
	);

	bctd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row_index  (row_index),
		.pixel_a    (pixel_a),
		.pixel_b    (pixel_b),
		.pixel_c    (pixel_c),
		.pixel_d    (pixel_d),
		.last_row   (last_row)
	);

	// rows of a block follow without a gap once started
	`BCTD_ASSERT_NXT(a_rows_contiguous, out_valid && out_ready && !last_row, out_valid)
	// rows advance in order, wrapping after the fourth
	`BCTD_ASSERT_NXT(a_row_order, out_valid && out_ready, !out_valid || row_index == 2'($past(row_index) + 2'd1))
	// the queue head is only released while it is valid
	`BCTD_ASSERT_IMP(a_pop_last, pop, head_valid)

endmodule

`default_nettype wire

/* dv/tb_block_texture_decoder_unit.sv */
// ---------------------------------------------------------------------------
// Block texture decoder testbench
// Sends BC1/BC2/BC3 compressed blocks through the decoder under random
// idling on both channels. Each accepted block is decoded by an in-bench
// copy of the decompression rules, and every emitted row is compared field
// by field against the oldest row still owed. Format writes happen only once
// the decoder has drained.
// ---------------------------------------------------------------------------
module tb_block_texture_decoder_unit;
	import bctd_pkg::*;

	// code 3 has no format of its own and decodes as BC1
	localparam logic [1:0] FMT_UNUSED  = 2'd3;
	localparam int         DRAIN_WAIT  = 4;
	localparam int         PHASE_LEN   = 56;
	localparam int         PHASES      = 8;

	// one queued transaction for the sender: a format write or a block
	typedef struct {
		bit          is_cfg;
		logic [1:0]  fmt;
		logic [63:0] ch;
		logic [63:0] ah;
	} block_job_t;

	// one decoded pixel row; px[0] is column 0
	typedef struct packed {
		logic [1:0]       row;
		logic [3:0][31:0] px;
		logic             last;
	} pixel_row_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data   = FMT_BC1;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [63:0] color_half = '0;
	logic [63:0] alpha_half = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [1:0]  row_index;
	logic [31:0] pixel_a, pixel_b, pixel_c, pixel_d;
	logic        last_row;

	block_job_t  block_jobs[$];
	pixel_row_t  rows_due[$];
	logic [1:0]  fmt_shadow = FMT_BC1;
	int          blocks_sent = 0;
	int          blocks_by_fmt[4] = '{0, 0, 0, 0};
	int          cfg_writes = 0;
	int          rows_checked = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          send_in, send_cfg;
	pixel_row_t  want, got;

	block_texture_decoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.color_half (color_half),
		.alpha_half (alpha_half),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row_index  (row_index),
		.pixel_a    (pixel_a),
		.pixel_b    (pixel_b),
		.pixel_c    (pixel_c),
		.pixel_d    (pixel_d),
		.last_row   (last_row)
	);

	always #5 clk = ~clk;

	// RGB565 to 8 bits per channel, top bits replicated into the low end
	function automatic logic [23:0] expand_565(input logic [15:0] c);
		logic [4:0] r5, b5;
		logic [5:0] g6;
		r5 = c[15:11];
		g6 = c[10:5];
		b5 = c[4:0];
		return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
	endfunction

	// decode one block under the current format and queue its four rows
	function automatic void decode_block(input logic [63:0] ch, input logic [63:0] ah);
		logic [3:0][31:0] cpal;
		logic [7:0]       apal [8];
		logic [7:0]       a0, a1;
		logic [31:0]      px;
		int unsigned      e0, e1;
		logic [3:0]       nib;
		int               k, row, col, p;
		bit               three;
		pixel_row_t       r;
		three = (fmt_shadow != FMT_BC2) && (fmt_shadow != FMT_BC3) &&
			(ch[15:0] <= ch[31:16]);
		cpal[0] = {8'hFF, expand_565(ch[15:0])};
		cpal[1] = {8'hFF, expand_565(ch[31:16])};
		cpal[2] = '0;
		cpal[3] = '0;
		// interpolated colour entries, alpha channel included
		for (k = 0; k < 4; k++) begin
			e0 = 32'(cpal[0][8*k +: 8]);
			e1 = 32'(cpal[1][8*k +: 8]);
			if (three) begin
				cpal[2][8*k +: 8] = 8'((e0 + e1) >> 1);
			end else begin
				cpal[2][8*k +: 8] = 8'((2 * e0 + e1) / 3);
				cpal[3][8*k +: 8] = 8'((e0 + 2 * e1) / 3);
			end
		end
		// BC3 alpha palette: 8-step when a0 > a1, else 6-step plus 0 and 255
		a0 = ah[7:0];
		a1 = ah[15:8];
		apal[0] = a0;
		apal[1] = a1;
		for (k = 2; k < 8; k++) begin
			if (a0 > a1)
				apal[k] = 8'(((8 - k) * a0 + (k - 1) * a1) / 7);
			else if (k < 6)
				apal[k] = 8'(((6 - k) * a0 + (k - 1) * a1) / 5);
			else
				apal[k] = (k == 6) ? 8'd0 : 8'd255;
		end
		for (row = 0; row < 4; row++) begin
			r.row  = 2'(row);
			r.last = (row == 3);
			for (col = 0; col < 4; col++) begin
				p  = 4 * row + col;
				px = cpal[ch[32 + 2*p +: 2]];
				if (fmt_shadow == FMT_BC2) begin
					nib = ah[4*p +: 4];
					px[31:24] = 8'(nib) * 8'd17;
				end else if (fmt_shadow == FMT_BC3) begin
					px[31:24] = apal[ah[16 + 3*p +: 3]];
				end
				r.px[col] = px;
			end
			rows_due.push_back(r);
		end
		blocks_by_fmt[fmt_shadow]++;
	endfunction

	// alpha half with endpoints a0/a1 and index p mod 8 at every pixel
	function automatic logic [63:0] bc3_alpha(input logic [7:0] a0, input logic [7:0] a1);
		logic [47:0] idx;
		int          p;
		for (p = 0; p < 16; p++)
			idx[3*p +: 3] = 3'(p % 8);
		return {idx, a1, a0};
	endfunction

	task automatic add_cfg(input logic [1:0] fmt);
		block_job_t j;
		j.is_cfg = 1'b1;
		j.fmt    = fmt;
		j.ch     = '0;
		j.ah     = '0;
		block_jobs.push_back(j);
	endtask

	task automatic add_block(input logic [63:0] ch, input logic [63:0] ah);
		block_job_t j;
		j.is_cfg = 1'b0;
		j.fmt    = FMT_BC1;
		j.ch     = ch;
		j.ah     = ah;
		block_jobs.push_back(j);
	endtask

	task automatic flag_row_field(input string field, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
		mismatches++;
	endtask

	// sender: blocks and format writes; a format write waits for a drained decoder
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			cfg_valid  <= 1'b0;
			color_half <= '0;
			alpha_half <= '0;
			cfg_data   <= FMT_BC1;
		end else begin
			if (in_valid && in_ready) begin
				decode_block(color_half, alpha_half);
				blocks_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				fmt_shadow = cfg_data;
				cfg_writes++;
			end
			send_in  = in_valid && !in_ready;
			send_cfg = cfg_valid && !cfg_ready;
			if (rows_due.size() == 0 && !in_valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!send_in && !send_cfg && block_jobs.size() > 0) begin
				if (block_jobs[0].is_cfg) begin
					if (quiet_cycles > DRAIN_WAIT) begin
						cfg_data <= block_jobs[0].fmt;
						send_cfg = 1'b1;
						quiet_cycles = 0;
						block_jobs.delete(0);
					end
				end else if ($urandom_range(99) >=
					((blocks_sent >= 250 && blocks_sent < 330) ? 0 : 20)) begin
					color_half <= block_jobs[0].ch;
					alpha_half <= block_jobs[0].ah;
					send_in = 1'b1;
					block_jobs.delete(0);
				end
			end
			in_valid  <= send_in;
			cfg_valid <= send_cfg;
		end
	end

	// receiver: random back-pressure, each row checked against the oldest owed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (rows_due.size() == 0) begin
					$display("%0t: row transaction with nothing owed, row_index %0d",
						$time, row_index);
					mismatches++;
				end else begin
					want     = rows_due.pop_front();
					got.row  = row_index;
					got.px   = {pixel_d, pixel_c, pixel_b, pixel_a};
					got.last = last_row;
					if (got.row !== want.row)
						flag_row_field("row_index", 32'(want.row), 32'(got.row));
					for (int c = 0; c < 4; c++)
						if (got.px[c] !== want.px[c])
							flag_row_field($sformatf("pixel column %0d", c),
								want.px[c], got.px[c]);
					if (got.last !== want.last)
						flag_row_field("last_row", 32'(want.last), 32'(got.last));
					rows_checked++;
				end
			end
			out_ready <= ($urandom_range(99) >=
				((rows_checked >= 1100 && rows_checked < 1400) ? 0 : 20));
		end
	end

	// stimulus list, reset, and end of run
	initial begin
		logic [63:0] ch, ah;
		logic [1:0]  fmt;
		int          ph, i;

		// BC1: four-colour, three-colour, equal endpoints, all transparent
		add_cfg(FMT_BC1);
		add_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, '1);
		add_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, '0);
		add_block({32'hE4E4E4E4, 16'h7BEF, 16'h7BEF}, 64'h0123456789ABCDEF);
		add_block({32'hFFFFFFFF, 16'h8410, 16'h1234}, '1);
		add_block('0, '0);
		add_block('1, '1);
		// BC2: explicit nibbles, four-colour forced even when c0 <= c1
		add_cfg(FMT_BC2);
		add_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'hFEDCBA9876543210);
		add_block({32'h1B1B1B1B, 16'h0000, 16'hFFFF}, '1);
		add_block({32'hFFFFFFFF, 16'h8410, 16'h1234}, '0);
		add_block({32'hE4E4E4E4, 16'h5555, 16'h5555}, 64'h0123456789ABCDEF);
		// BC3: both alpha modes, equal endpoints, extremes
		add_cfg(FMT_BC3);
		add_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, bc3_alpha(8'hFF, 8'h00));
		add_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, bc3_alpha(8'h00, 8'hFF));
		add_block({32'h4E4E4E4E, 16'hA5A5, 16'hA5A5}, bc3_alpha(8'h80, 8'h80));
		add_block({32'hB1B1B1B1, 16'h1234, 16'h8410}, bc3_alpha(8'hC8, 8'h37));
		add_block({32'hE4E4E4E4, 16'h8410, 16'h1234}, bc3_alpha(8'h37, 8'hC8));
		add_block('1, '1);
		add_block('0, '0);
		// unused format code behaves as BC1
		add_cfg(FMT_UNUSED);
		add_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, '1);
		add_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, '0);

		// random phases cycling through every format setting
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: fmt = FMT_BC2;
				1: fmt = FMT_BC3;
				2: fmt = FMT_UNUSED;
				default: fmt = FMT_BC1;
			endcase
			add_cfg(fmt);
			for (i = 0; i < PHASE_LEN; i++) begin
				ch = {$urandom, $urandom};
				ah = {$urandom, $urandom};
				case ($urandom_range(9))
					0: ch[31:16] = ch[15:0];
					1: ah[15:8] = ah[7:0];
					2: ah[15:0] = $urandom_range(1) ? 16'h00FF : 16'hFF00;
					3: ch[31:0] = $urandom_range(1) ? 32'h0000FFFF : 32'hFFFF0000;
					default: ;
				endcase
				add_block(ch, ah);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (block_jobs.size() != 0 || in_valid || cfg_valid || rows_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Decoded %0d blocks (BC1 %0d, BC2 %0d, BC3 %0d, code 3 %0d), %0d format writes",
			blocks_sent, blocks_by_fmt[FMT_BC1], blocks_by_fmt[FMT_BC2],
			blocks_by_fmt[FMT_BC3], blocks_by_fmt[FMT_UNUSED], cfg_writes);
		$display("Compared %0d pixel rows, %0d mismatches", rows_checked, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hang guard
	initial begin
		#2000000;
		$display("Timed out with %0d rows still owed", rows_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
